[sv/mpq_pkg.sv]
// Shared types and codes for the minimum priority queue.
`timescale 1ns / 1ps

package mpq_pkg;

   // Operation codes of a request
   typedef enum logic {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } op_type;

   // Status codes of a response
   typedef enum logic [1:0] {
      ST_ENQ   = 2'd0,
      ST_DEQ   = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // One request transfer
   typedef struct packed {
      op_type             op;
      logic signed [31:0] item_data;
      logic signed [31:0] item_priority;
   } req_type;

   // One response transfer
   typedef struct packed {
      status_type         status;
      logic signed [31:0] out_data;
      logic signed [31:0] out_priority;
      logic [4:0]         occupancy;
   } rsp_type;

   // One stored queue entry
   typedef struct packed {
      logic signed [31:0] data;
      logic signed [31:0] prio;
   } entry_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       enq_write;
      logic       scan_init;
      logic       scan;
      logic       shift_init;
      logic       shift;
      logic       deq_commit;
      logic       rsp_en;
      status_type rsp_status;
   } ctl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic full;
      logic empty;
      logic scan_done;
      logic shift_done;
   } dp_stat_type;

endpackage

[sv/mpq_datapath.sv]
// Datapath of the minimum priority queue: entry memory, scan and compaction walk.
`timescale 1ns / 1ps

module mpq_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mpq_pkg::req_type     req_item,
   input  mpq_pkg::ctl_cmd_type cmd,
   output mpq_pkg::dp_stat_type stat,
   output logic                 rsp_valid,
   output mpq_pkg::rsp_type     rsp_item
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   // Entries held oldest first
   mpq_pkg::entry_type slot_mem_ff [CAPACITY];

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [CW-1:0]      rix_ff;
   logic               rvalid_ff;
   mpq_pkg::entry_type rdata_ff;
   mpq_pkg::entry_type best_ff;
   logic [IW-1:0]      best_ix_ff;
   logic               rsp_valid_ff;
   mpq_pkg::rsp_type   rsp_ff;

   logic               rd_en;
   logic               mem_we;
   logic [CW-1:0]      wrx;
   logic [IW-1:0]      mem_wa;
   mpq_pkg::entry_type mem_wd;
   logic               take_best;
   logic [31:0]        count_wide;

   // Status toward the controller
   assign stat.full       = (count_ff == CW'(CAPACITY));
   assign stat.empty      = (count_ff == '0);
   assign stat.scan_done  = rvalid_ff && (rix_ff == count_ff - CW'(1));
   assign stat.shift_done = (ptr_ff >= count_ff) && !rvalid_ff;

   // Read issue, write port and compare
   always_comb begin
      rd_en     = (cmd.scan || cmd.shift) && (ptr_ff < count_ff);
      wrx       = rix_ff - CW'(1);
      mem_we    = cmd.enq_write || (cmd.shift && rvalid_ff);
      mem_wa    = cmd.enq_write ? count_ff[IW-1:0] : wrx[IW-1:0];
      mem_wd    = rdata_ff;
      if (cmd.enq_write) begin
         mem_wd.data = req_item.item_data;
         mem_wd.prio = req_item.item_priority;
      end
      // strict less keeps the earliest of equal priorities
      take_best = (rix_ff == '0) || ($signed(rdata_ff.prio) < $signed(best_ff.prio));
   end

   // Next pointer and occupancy
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.scan_init) begin
         ptr_in = '0;
      end else if (cmd.shift_init) begin
         ptr_in = CW'(best_ix_ff) + CW'(1);
      end else if (rd_en) begin
         ptr_in = ptr_ff + CW'(1);
      end

      count_in = count_ff;
      if (cmd.enq_write) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.deq_commit) begin
         count_in = count_ff - CW'(1);
      end
      count_wide = 32'(count_in);
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rdata_ff <= slot_mem_ff[ptr_ff[IW-1:0]];
         rix_ff   <= ptr_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rvalid_ff    <= rd_en;
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   // Running minimum and response payload
   always_ff @(posedge clock) begin
      if (cmd.scan && rvalid_ff && take_best) begin
         best_ff    <= rdata_ff;
         best_ix_ff <= rix_ff[IW-1:0];
      end
      if (cmd.rsp_en) begin
         rsp_ff.status    <= cmd.rsp_status;
         rsp_ff.occupancy <= count_wide[4:0];
         if (cmd.rsp_status == mpq_pkg::ST_DEQ) begin
            rsp_ff.out_data     <= best_ff.data;
            rsp_ff.out_priority <= best_ff.prio;
         end else begin
            rsp_ff.out_data     <= '0;
            rsp_ff.out_priority <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[sv/mpq_controller.sv]
// Controller of the minimum priority queue: sequences enqueue, scan and compaction.
`timescale 1ns / 1ps

module mpq_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  mpq_pkg::op_type      op,
   input  mpq_pkg::dp_stat_type stat,
   output mpq_pkg::ctl_cmd_type cmd,
   output logic                 busy
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_INIT,
      S_SHIFT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      accept;

   // Next state and commands
   always_comb begin
      accept   = start && !busy_ff;
      state_in = state_ff;
      busy_in  = busy_ff;
      cmd      = '0;
      cmd.rsp_status = mpq_pkg::ST_ENQ;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (op == mpq_pkg::OP_ENQ) begin
                  cmd.rsp_en = 1'b1;
                  if (stat.full) begin
                     cmd.rsp_status = mpq_pkg::ST_FULL;
                  end else begin
                     cmd.enq_write  = 1'b1;
                     cmd.rsp_status = mpq_pkg::ST_ENQ;
                  end
               end else if (stat.empty) begin
                  cmd.rsp_en     = 1'b1;
                  cmd.rsp_status = mpq_pkg::ST_EMPTY;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
                  busy_in       = 1'b1;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_SHIFT_INIT;
            end
         end
         S_SHIFT_INIT: begin
            cmd.shift_init = 1'b1;
            state_in       = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               cmd.deq_commit = 1'b1;
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = mpq_pkg::ST_DEQ;
               state_in       = S_IDLE;
               busy_in        = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   // State and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

[sv/min_priority_queue_unit.sv]
// Top level of the bounded stable minimum priority queue.
`timescale 1ns / 1ps
//
// A request transfer happens at a clock edge with start high and busy low.
// req_item.op selects enqueue (append data and signed priority behind all
// held entries) or dequeue (remove the entry with the smallest priority;
// among equal priorities the oldest one goes, the rest keep their order).
// Every request gives one response: rsp_valid is high for one cycle with
// rsp_item holding status, the dequeued entry (zero otherwise) and the
// occupancy after the request. The receiver cannot hold a response off.
// Enqueue, full enqueue and empty dequeue: response in the cycle after the
// transfer, busy stays low, so these run at one request per cycle.
// Dequeue: entries sit oldest first in a single-port-read memory; one pass
// reads all N held entries to find the minimum, then, after one setup
// step, the entries behind it move down one slot each.
// busy is high meanwhile and drops with the response strobe.
// Reset (synchronous) empties the queue; the memory is not cleared, since
// only slots below the occupancy are ever read.
//
module min_priority_queue_unit #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mpq_pkg::req_type req_item,
   output logic             rsp_valid,
   output mpq_pkg::rsp_type rsp_item
);

   mpq_pkg::ctl_cmd_type cmd;
   mpq_pkg::dp_stat_type stat;

   // Sequencer
   mpq_controller u_ctl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_item.op),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Storage and compare
   mpq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

[sv/mpq_checker.sv]
// Port-level checks of the minimum priority queue and their binding.
`timescale 1ns / 1ps

module mpq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input mpq_pkg::req_type req_item,
   input logic             rsp_valid,
   input mpq_pkg::rsp_type rsp_item
);

   // An enqueue transfer answers in the next cycle as enqueued or full
   a_enq_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.op == mpq_pkg::OP_ENQ) |=>
         (rsp_valid && (rsp_item.status == mpq_pkg::ST_ENQ ||
                        rsp_item.status == mpq_pkg::ST_FULL)))
      else $error("enqueue not answered in the next cycle");

   // A response follows a transfer or ends a busy period
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start && !busy) || $past(busy)))
      else $error("response without a request");

   // End of a dequeue walk delivers the dequeued entry
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |->
         (rsp_valid && rsp_item.status == mpq_pkg::ST_DEQ))
      else $error("busy dropped without a dequeue response");

   // Only a dequeue returns entry fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != mpq_pkg::ST_DEQ) |->
         (rsp_item.out_data == '0 && rsp_item.out_priority == '0))
      else $error("nonzero entry fields on a non-dequeue response");

   // An empty dequeue reports zero occupancy
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == mpq_pkg::ST_EMPTY) |->
         (rsp_item.occupancy == 5'd0))
      else $error("empty response with nonzero occupancy");

endmodule

bind min_priority_queue_unit mpq_checker u_mpq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
